FILE: src/stride_prefetch_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stride prefetch table
// Each macro checks a property on the rising edge of clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STRIDE_PREFETCH_TABLE_ASSERT_SVH
`define STRIDE_PREFETCH_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent true implies consequent true in the same cycle
`define SPT_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stride prefetch table: same-cycle check failed");

// antecedent true implies consequent true in the next cycle
`define SPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stride prefetch table: next-cycle check failed");

`else

`define SPT_ASSERT_IMPLY(label, ante, cons)
`define SPT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants of the stride prefetch table.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int ADDR_W              = 32;
  localparam int OFFSET_BITS_DEFAULT = 5;
  localparam int INDEX_BITS_DEFAULT  = 10;
  localparam int TABLE_DEPTH_DEFAULT = 1024;

  typedef enum logic {
    ITEM_ACCESS   = 1'b0,
    ITEM_COMPLETE = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOKUP
  } back_state_t;

  // one classified beat as it sits in the front queue
  typedef struct packed {
    item_kind_t        kind;
    logic              hit_l2;
    logic [ADDR_W-1:0] addr;
  } queue_item_t;

endpackage

FILE: src/spt_ram.sv
// ----------------------------------------------------------------------------
// spt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/spt_front.sv
// ----------------------------------------------------------------------------
// spt_front
// Input side: accept beats, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module spt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic                      in_req_type,
  input  logic [spt_pkg::ADDR_W-1:0] in_addr,
  input  logic                      in_hit_l2,
  input  logic                      clearing,
  output logic                      q_valid,
  output spt_pkg::queue_item_t      q_item,
  input  logic                      q_ready
);

  spt_pkg::queue_item_t slot_r [2];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           count_r, count_nxt;
  logic                 take;
  logic                 drain;
  spt_pkg::queue_item_t item_in;

  // hold off new beats while the table is being cleared
  assign full  = (count_r == 2'd2) || clearing;
  assign take  = push && !full;
  assign drain = q_ready && (count_r != 2'd0);

  always_comb begin
    item_in.kind   = in_req_type ? spt_pkg::ITEM_COMPLETE : spt_pkg::ITEM_ACCESS;
    item_in.hit_l2 = in_hit_l2;
    item_in.addr   = in_addr;
  end

  always_comb begin
    wr_ptr_nxt = take  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = drain ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, take} - {1'b0, drain};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

  assign q_valid = (count_r != 2'd0);
  assign q_item  = slot_r[rd_ptr_r];

endmodule

FILE: src/spt_back.sv
// ----------------------------------------------------------------------------
// spt_back
// Table side: clear pass, table lookup and update, pending prefetch, result slot.
// ----------------------------------------------------------------------------
`include "stride_prefetch_table_assert.svh"

module spt_back #(
  parameter int OFFSET_BITS = spt_pkg::OFFSET_BITS_DEFAULT,
  parameter int INDEX_BITS  = spt_pkg::INDEX_BITS_DEFAULT,
  parameter int TABLE_DEPTH = spt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  spt_pkg::queue_item_t       q_item,
  output logic                       q_ready,
  output logic                       clearing,
  output logic                       empty,
  input  logic                       pop,
  output logic                       out_pending,
  output logic [spt_pkg::ADDR_W-1:0] out_prefetch_addr
);

  localparam int RAM_AW  = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W = 2 * INDEX_BITS + 1;
  localparam int EXP_W   = INDEX_BITS + 2;
  localparam int AW      = spt_pkg::ADDR_W;

  spt_pkg::back_state_t state_r, state_nxt;
  logic [RAM_AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        np_r, np_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_pend_r, out_pend_nxt;
  logic [AW-1:0]        out_addr_r, out_addr_nxt;

  logic                 ram_we;
  logic [RAM_AW-1:0]    ram_waddr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic                 ram_re;
  logic [RAM_AW-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [INDEX_BITS-1:0]        cur_in;
  logic [INDEX_BITS-1:0]        cur_r;
  logic [INDEX_BITS-1:0]        prev_idx;
  logic signed [INDEX_BITS:0]   stride_s;
  logic signed [EXP_W-1:0]      expect_s;
  logic                         match;
  logic [INDEX_BITS:0]          new_stride;
  logic [AW-1:0]                stride_ext;
  logic [AW-1:0]                pf_addr;
  logic                         slot_free;

  spt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_in = q_item.addr[OFFSET_BITS +: INDEX_BITS];
  assign cur_r  = addr_r[OFFSET_BITS +: INDEX_BITS];

  // entry = {previous block index, signed stride in blocks}
  always_comb begin
    prev_idx   = ram_rdata[ENTRY_W-1 -: INDEX_BITS];
    stride_s   = signed'(ram_rdata[INDEX_BITS:0]);
    expect_s   = signed'({2'b00, prev_idx}) + EXP_W'(stride_s);
    match      = (expect_s == signed'({2'b00, cur_r}));
    new_stride = match ? ram_rdata[INDEX_BITS:0] : ({1'b0, cur_r} - {1'b0, prev_idx});
    stride_ext = AW'(stride_s);
    pf_addr    = match ? (addr_r + (stride_ext << OFFSET_BITS))
                       : (addr_r + (AW'(1) << OFFSET_BITS));
  end

  assign slot_free = !out_valid_r || pop;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    pend_nxt      = pend_r;
    np_nxt        = np_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r;
    out_pend_nxt  = out_pend_r;
    out_addr_nxt  = out_addr_r;
    q_ready       = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = clr_cnt_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = RAM_AW'(cur_in);

    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      spt_pkg::BK_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt_r == RAM_AW'(TABLE_DEPTH - 1)) begin
          state_nxt = spt_pkg::BK_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      spt_pkg::BK_IDLE: begin
        if (q_valid && slot_free) begin
          q_ready = 1'b1;
          if (q_item.kind == spt_pkg::ITEM_COMPLETE) begin
            pend_nxt      = 1'b0;
            out_valid_nxt = 1'b1;
            out_pend_nxt  = 1'b0;
            out_addr_nxt  = '0;
          end else if (q_item.hit_l2 && pend_r) begin
            // drop the access, report the waiting prefetch
            out_valid_nxt = 1'b1;
            out_pend_nxt  = 1'b1;
            out_addr_nxt  = np_r;
          end else begin
            ram_re    = 1'b1;
            addr_nxt  = q_item.addr;
            state_nxt = spt_pkg::BK_LOOKUP;
          end
        end
      end
      spt_pkg::BK_LOOKUP: begin
        ram_we        = 1'b1;
        ram_waddr     = RAM_AW'(cur_r);
        ram_wdata     = {cur_r, new_stride};
        pend_nxt      = 1'b1;
        np_nxt        = pf_addr;
        out_valid_nxt = 1'b1;
        out_pend_nxt  = 1'b1;
        out_addr_nxt  = pf_addr;
        state_nxt     = spt_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = spt_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spt_pkg::BK_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      np_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      np_r        <= np_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    out_pend_r <= out_pend_nxt;
    out_addr_r <= out_addr_nxt;
  end

  assign clearing          = (state_r == spt_pkg::BK_CLEAR);
  assign empty             = !out_valid_r;
  assign out_pending       = out_pend_r;
  assign out_prefetch_addr = out_addr_r;

  `SPT_ASSERT_IMPLY(a_lookup_slot_free, state_r == spt_pkg::BK_LOOKUP, !out_valid_r)
  `SPT_ASSERT_NEXT(a_read_then_lookup, ram_re, state_r == spt_pkg::BK_LOOKUP)
  `SPT_ASSERT_IMPLY(a_no_take_in_clear, state_r == spt_pkg::BK_CLEAR, !q_ready)
  `SPT_ASSERT_NEXT(a_lookup_delivers, state_r == spt_pkg::BK_LOOKUP, out_valid_r && out_pend_r)

endmodule

FILE: src/stride_prefetch_table.sv
// ----------------------------------------------------------------------------
// stride_prefetch_table
// Stride prefetcher on a reference prediction table, queue-style ports.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_req_type / in_addr / in_hit_l2 and raise push; the
//   beat is taken at an edge where push is high and full is low. A CPU access
//   (req_type 0) looks up and updates the table, unless it hits L2 while a
//   prefetch is waiting; a completion (req_type 1) clears the waiting prefetch.
//   Result channel: every input beat yields one result beat (out_pending,
//   out_prefetch_addr). It is valid while empty is low and leaves at an edge
//   where pop is high.
//   Path: a completion or an access dropped on an L2 hit goes from the queue
//   straight to the result register; a table access waits on the registered
//   table read, and the update and its result follow in the next cycle.
//   Throughput: one beat per cycle for completions and dropped accesses while
//   the result slot is free or popped; the next beat waits out a table access.
//   Reset: the table is swept to zero, one entry per cycle, over all
//   TABLE_DEPTH entries; full stays high during the sweep.
//   Stall: while pop is low the result holds; a two-entry queue keeps taking
//   beats until it fills, then full rises.
// ----------------------------------------------------------------------------
module stride_prefetch_table #(
  parameter int OFFSET_BITS = spt_pkg::OFFSET_BITS_DEFAULT,
  parameter int INDEX_BITS  = spt_pkg::INDEX_BITS_DEFAULT,
  parameter int TABLE_DEPTH = spt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       push,
  output logic                       full,
  input  logic                       in_req_type,
  input  logic [spt_pkg::ADDR_W-1:0] in_addr,
  input  logic                       in_hit_l2,
  // result channel
  output logic                       empty,
  input  logic                       pop,
  output logic                       out_pending,
  output logic [spt_pkg::ADDR_W-1:0] out_prefetch_addr
);

  // front-to-back queue handshake
  logic                 q_valid;
  logic                 q_ready;
  spt_pkg::queue_item_t q_item;
  // back tells front to hold intake during the table sweep
  logic                 clearing;

  // accept and classify beats; park them in the queue
  spt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_req_type (in_req_type),
    .in_addr     (in_addr),
    .in_hit_l2   (in_hit_l2),
    .clearing    (clearing),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_ready     (q_ready)
  );

  // run the table update and drive the result slot
  spt_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .INDEX_BITS  (INDEX_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_ready           (q_ready),
    .clearing          (clearing),
    .empty             (empty),
    .pop               (pop),
    .out_pending       (out_pending),
    .out_prefetch_addr (out_prefetch_addr)
  );

endmodule
